@@ src/mdpm_pkg.sv @@
// Shared types, constants and the slot role table of the mono downmix peak meter.
`default_nettype none

package mdpm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int GAIN_BITS_DEF   = 16;
    localparam int SLOTS           = 5;
    localparam int SLOT_IDX_BITS   = $clog2(SLOTS);

    localparam int MODE_BITS     = 3;
    localparam int LEVEL_BITS    = 16;
    localparam int LEVEL_FRAC    = 15;
    localparam int CFG_ADDR_BITS = 4;

    localparam logic [LEVEL_BITS-1:0] LEVEL_UNITY = 16'd32768;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 16'd23170;
    localparam logic [MODE_BITS-1:0]  MODE_RESET  = 3'd7;
    localparam logic [MODE_BITS-1:0]  MODE_MONO   = 3'd1;

    // 2^-0.5 in Q0.32
    localparam logic [63:0] ROOT_HALF_Q32 = 64'd3037000500;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_CLEV = 2'd1;
    localparam logic [1:0] REG_SLEV = 2'd2;

    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_FRONT,
        ROLE_CENTRE,
        ROLE_SURR
    } role_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [LEVEL_BITS-1:0] clev;
        logic [LEVEL_BITS-1:0] slev;
    } cfg_t;

    // coded channel order per acmod
    localparam role_t ROLE_MAP [8][SLOTS] = '{
        '{ROLE_NONE,   ROLE_NONE,   ROLE_NONE,  ROLE_NONE, ROLE_NONE},
        '{ROLE_CENTRE, ROLE_NONE,   ROLE_NONE,  ROLE_NONE, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_FRONT,  ROLE_NONE,  ROLE_NONE, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_CENTRE, ROLE_FRONT, ROLE_NONE, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_FRONT,  ROLE_SURR,  ROLE_NONE, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_CENTRE, ROLE_FRONT, ROLE_SURR, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_FRONT,  ROLE_SURR,  ROLE_SURR, ROLE_NONE},
        '{ROLE_FRONT,  ROLE_CENTRE, ROLE_FRONT, ROLE_SURR, ROLE_SURR}
    };

endpackage

`default_nettype wire

@@ src/mdpm_divider.sv @@
// Restoring divider, one quotient bit per cycle, for gain normalization.
`default_nettype none

module mdpm_divider #(
    parameter int GAIN_BITS = mdpm_pkg::GAIN_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           clear,
    input  wire logic                           start,
    input  wire logic [2*GAIN_BITS-1:0]         num,
    input  wire logic [GAIN_BITS+2:0]           den,
    output logic                                done,
    output logic [GAIN_BITS-1:0]                quot
);

    localparam int SUM_BITS = GAIN_BITS + 3;
    localparam int NUM_BITS = 2 * GAIN_BITS;
    localparam int CNT_BITS = $clog2(GAIN_BITS + 1);

    logic                  active_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SUM_BITS-1:0]   rem_reg;
    logic [SUM_BITS-1:0]   den_reg;
    logic [GAIN_BITS-1:0]  quo_reg;

    logic [SUM_BITS:0]     trial;
    logic                  fits;
    logic [SUM_BITS:0]     diff;

    always_comb begin
        trial = {rem_reg, quo_reg[GAIN_BITS-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else if (clear) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else if (start) begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= CNT_BITS'(GAIN_BITS);
        end else if (active_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {3'b000, num[NUM_BITS-1:GAIN_BITS]};
            quo_reg <= num[GAIN_BITS-1:0];
            den_reg <= den;
        end else if (active_reg) begin
            rem_reg <= fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
            quo_reg <= {quo_reg[GAIN_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

@@ src/mdpm_gain_calc.sv @@
// Mix gain sequencer: role gains, sum, and normalization through the shared divider.
`default_nettype none

module mdpm_gain_calc #(
    parameter int GAIN_BITS = mdpm_pkg::GAIN_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          restart,
    input  wire mdpm_pkg::cfg_t cfg,
    output logic               busy,
    output logic [GAIN_BITS-1:0] gain [mdpm_pkg::SLOTS]
);

    import mdpm_pkg::*;

    localparam int GF        = GAIN_BITS - 1;
    localparam int SUM_BITS  = GAIN_BITS + 3;
    localparam int NUM_BITS  = 2 * GAIN_BITS;
    localparam int PROD_BITS = LEVEL_BITS + GAIN_BITS;

    localparam logic [63:0] MINUS3_W = (ROOT_HALF_Q32 + (64'd1 << (31 - GF))) >> (32 - GF);
    localparam logic [63:0] PLUS3_W  = (ROOT_HALF_Q32 + (64'd1 << (30 - GF))) >> (31 - GF);
    localparam logic [GAIN_BITS-1:0] MINUS3 = MINUS3_W[GAIN_BITS-1:0];
    localparam logic [GAIN_BITS-1:0] PLUS3  = PLUS3_W[GAIN_BITS-1:0];
    localparam logic [GAIN_BITS-1:0] UNITY  = {1'b1, {GF{1'b0}}};
    localparam logic [PROD_BITS-1:0] PROD_HALF =
        {{(PROD_BITS - LEVEL_FRAC){1'b0}}, 1'b1, {(LEVEL_FRAC - 1){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_GAIN = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [PROD_BITS-1:0]     prod_c_reg, prod_s_reg;
    logic [GAIN_BITS-1:0]     raw_reg [SLOTS];
    logic [GAIN_BITS-1:0]     gain_reg [SLOTS];
    logic [SUM_BITS-1:0]      sum_reg;
    logic [SLOT_IDX_BITS-1:0] slot_reg;
    logic                     launched_reg;

    logic [LEVEL_BITS-1:0]    clev_sat, slev_sat;
    logic [PROD_BITS-1:0]     rnd_c, rnd_s;
    logic [GAIN_BITS-1:0]     gain_c, gain_s;
    logic [GAIN_BITS-1:0]     raw_next [SLOTS];
    logic [SUM_BITS-1:0]      sum_next;
    logic                     needs_norm;
    logic                     last_slot;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_BITS-1:0]      div_num;
    logic [GAIN_BITS-1:0]     div_quot;

    always_comb begin
        clev_sat = (cfg.clev > LEVEL_UNITY) ? LEVEL_UNITY : cfg.clev;
        slev_sat = (cfg.slev > LEVEL_UNITY) ? LEVEL_UNITY : cfg.slev;
        rnd_c    = prod_c_reg + PROD_HALF;
        rnd_s    = prod_s_reg + PROD_HALF;
        gain_c   = rnd_c[LEVEL_FRAC +: GAIN_BITS];
        gain_s   = rnd_s[LEVEL_FRAC +: GAIN_BITS];
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            case (ROLE_MAP[cfg.mode][i])
                ROLE_FRONT:  raw_next[i] = MINUS3;
                ROLE_CENTRE: raw_next[i] = (cfg.mode == MODE_MONO) ? UNITY : gain_c;
                ROLE_SURR:   raw_next[i] = gain_s;
                default:     raw_next[i] = '0;
            endcase
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < SLOTS; i++) begin
            sum_next = sum_next + SUM_BITS'(raw_reg[i]);
        end
    end

    assign needs_norm = sum_reg > SUM_BITS'(UNITY);
    assign last_slot  = slot_reg == SLOT_IDX_BITS'(SLOTS - 1);
    assign div_num    = {1'b0, raw_reg[slot_reg], {GF{1'b0}}} + NUM_BITS'(sum_reg >> 1);

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV: begin
                if (!needs_norm) begin
                    state_next = ST_IDLE;
                end else if (!launched_reg) begin
                    div_start = 1'b1;
                end else if (div_done && last_slot) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (restart) begin
            state_next = ST_MUL;
            div_start  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_MUL;
            slot_reg     <= '0;
            launched_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (restart || state_reg != ST_DIV) begin
                slot_reg     <= '0;
                launched_reg <= 1'b0;
            end else if (div_start) begin
                launched_reg <= 1'b1;
            end else if (div_done && !last_slot) begin
                slot_reg     <= slot_reg + 1'b1;
                launched_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_c_reg <= {{GAIN_BITS{1'b0}}, clev_sat} * {{LEVEL_BITS{1'b0}}, PLUS3};
            prod_s_reg <= {{GAIN_BITS{1'b0}}, slev_sat} * {{LEVEL_BITS{1'b0}}, MINUS3};
        end
        if (state_reg == ST_GAIN) begin
            raw_reg <= raw_next;
        end
        if (state_reg == ST_SUM) begin
            sum_reg <= sum_next;
        end
        if (state_reg == ST_DIV && !restart) begin
            if (!needs_norm) begin
                gain_reg <= raw_reg;
            end else if (div_done) begin
                gain_reg[slot_reg] <= div_quot;
            end
        end
    end

    mdpm_divider #(
        .GAIN_BITS (GAIN_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (restart),
        .start   (div_start),
        .num     (div_num),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign busy = state_reg != ST_IDLE;
    assign gain = gain_reg;

endmodule

`default_nettype wire

@@ src/mdpm_lane.sv @@
// One downmix lane: registered product of a slot sample and its mix gain.
`default_nettype none

module mdpm_lane #(
    parameter int SAMPLE_BITS = mdpm_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = mdpm_pkg::GAIN_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic        [GAIN_BITS-1:0]          gain,
    output logic      signed [SAMPLE_BITS+GAIN_BITS-1:0] product
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS;

    logic signed [PW:0]   full;
    logic signed [PW-1:0] product_reg;

    assign full = sample * $signed({1'b0, gain});

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= full[PW-1:0];
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

@@ src/mdpm_merge.sv @@
// Merge of lane products: adder tree, magnitude, rounding, saturation and peak hold.
`default_nettype none

module mdpm_merge #(
    parameter int SAMPLE_BITS = mdpm_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = mdpm_pkg::GAIN_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_final,
    output logic                                       in_ready,
    input  wire logic signed [SAMPLE_BITS+GAIN_BITS-1:0] prod [mdpm_pkg::SLOTS],
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_tdata
);

    localparam int PW       = SAMPLE_BITS + GAIN_BITS;
    localparam int SW       = PW + 3;
    localparam int GF       = GAIN_BITS - 1;
    localparam int OUT_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [SW-1:0] HALF = SW'({1'b1, {(GF - 1){1'b0}}});
    localparam logic [SW-1:0] SAMPLE_UNITY = SW'({1'b1, {(SAMPLE_BITS - 1){1'b0}}});

    logic                   v3_reg, v4_reg, v5_reg, v6_reg;
    logic                   f3_reg, f4_reg, f5_reg, f6_reg;
    logic signed [SW-1:0]   p01_reg, p23_reg, p4_reg;
    logic signed [SW-1:0]   total_reg;
    logic [SW-1:0]          abs_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic                   out_valid_reg;

    logic                   out_free, take6;
    logic                   rdy3, rdy4, rdy5, rdy6;
    logic [SW-1:0]          rnd, scaled;
    logic [SAMPLE_BITS-1:0] mag_next, peak_next;

    assign out_free = !out_valid_reg || m_tready;
    assign take6    = v6_reg && (!f6_reg || out_free);
    assign rdy6     = !v6_reg || take6;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_comb begin
        rnd       = abs_reg + HALF;
        scaled    = rnd >> GF;
        mag_next  = (scaled > SAMPLE_UNITY) ? SAMPLE_UNITY[SAMPLE_BITS-1:0]
                                            : scaled[SAMPLE_BITS-1:0];
        peak_next = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            if (rdy3) v3_reg <= in_valid;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (take6) begin
                peak_reg <= f6_reg ? '0 : peak_next;
            end
            if (take6 && f6_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            f3_reg  <= in_final;
            p01_reg <= SW'(prod[0]) + SW'(prod[1]);
            p23_reg <= SW'(prod[2]) + SW'(prod[3]);
            p4_reg  <= SW'(prod[4]);
        end
        if (rdy4) begin
            f4_reg    <= f3_reg;
            total_reg <= p01_reg + p23_reg + p4_reg;
        end
        if (rdy5) begin
            f5_reg  <= f4_reg;
            abs_reg <= total_reg[SW-1] ? SW'(-total_reg) : SW'(total_reg);
        end
        if (rdy6) begin
            f6_reg  <= f5_reg;
            mag_reg <= mag_next;
        end
        if (take6 && f6_reg) begin
            out_reg <= peak_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'(out_reg);

endmodule

`default_nettype wire

@@ src/mono_downmix_peak_meter.sv @@
// Top level of the mono downmix peak meter: register port, input stage, lanes and merge.
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tdata: sample_slot0..4 (SAMPLE_BITS each), tlast: final_frame
//  m_*      | out       | tdata: peak_linear (SAMPLE_BITS)
//  p*       | in        | channel_mode @0x0, centre_level @0x4, surround_level @0x8
//
// One item per cycle while s_tready is high; a peak reaches m_tdata through the input
// stage, lane product, merge stages and output register. Gains come from a
// sequencer with a one-bit-per-cycle divider: s_tready stays low after reset or a
// register write until the gains are derived, dividing only when they sum above unity.
// Reset is synchronous, active low, and clears control state and the peak.
// A waiting peak stalls nothing until the next final item reaches the last merge stage;
// up to five more items are then taken before s_tready drops.
`default_nettype none

module mono_downmix_peak_meter #(
    parameter int SAMPLE_BITS = mdpm_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = mdpm_pkg::GAIN_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // sample_slot0, sample_slot1, sample_slot2, sample_slot3, sample_slot4
    input  wire logic [((mdpm_pkg::SLOTS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                                          s_tlast,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // peak_linear
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]                   m_tdata,
    input  wire logic                                          psel,
    input  wire logic                                          penable,
    input  wire logic                                          pwrite,
    input  wire logic [mdpm_pkg::CFG_ADDR_BITS-1:0]            paddr,
    input  wire logic [31:0]                                   pwdata,
    output logic [31:0]                                        prdata,
    output logic                                               pready
);

    import mdpm_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_BITS;

    cfg_t                          cfg_reg;
    logic                          measuring_reg;
    logic [GAIN_BITS-1:0]          mix_gain_reg [SLOTS];
    logic                          v1_reg, f1_reg;
    logic signed [SAMPLE_BITS-1:0] samp1_reg [SLOTS];
    logic [GAIN_BITS-1:0]          gain1_reg [SLOTS];
    logic                          v2_reg, f2_reg;

    logic                          cfg_wr;
    logic                          s_fire;
    logic                          gain_busy;
    logic [GAIN_BITS-1:0]          pend_gain [SLOTS];
    logic signed [PW-1:0]          prod [SLOTS];
    logic                          merge_ready;
    logic                          rdy1, rdy2;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode <= MODE_RESET;
            cfg_reg.clev <= LEVEL_RESET;
            cfg_reg.slev <= LEVEL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[CFG_ADDR_BITS-1:2])
                REG_MODE: cfg_reg.mode <= pwdata[MODE_BITS-1:0];
                REG_CLEV: cfg_reg.clev <= pwdata[LEVEL_BITS-1:0];
                REG_SLEV: cfg_reg.slev <= pwdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[CFG_ADDR_BITS-1:2])
            REG_MODE: prdata = {{(32 - MODE_BITS){1'b0}}, cfg_reg.mode};
            REG_CLEV: prdata = {{(32 - LEVEL_BITS){1'b0}}, cfg_reg.clev};
            REG_SLEV: prdata = {{(32 - LEVEL_BITS){1'b0}}, cfg_reg.slev};
            default:  prdata = '0;
        endcase
    end

    mdpm_gain_calc #(
        .GAIN_BITS (GAIN_BITS)
    ) u_gain_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_wr),
        .cfg     (cfg_reg),
        .busy    (gain_busy),
        .gain    (pend_gain)
    );

    assign rdy2     = !v2_reg || merge_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && !gain_busy && !cfg_wr;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measuring_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            if (s_fire) measuring_reg <= !s_tlast;
            if (rdy1)   v1_reg <= s_fire;
            if (rdy2)   v2_reg <= v1_reg;
        end
    end

    // first item of a measurement latches the freshly derived gains
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            f1_reg <= s_tlast;
            for (int i = 0; i < SLOTS; i++) begin
                samp1_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                gain1_reg[i] <= measuring_reg ? mix_gain_reg[i] : pend_gain[i];
            end
            if (!measuring_reg) begin
                mix_gain_reg <= pend_gain;
            end
        end
        if (rdy2) begin
            f2_reg <= f1_reg;
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        mdpm_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .GAIN_BITS   (GAIN_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (rdy2),
            .sample  (samp1_reg[g]),
            .gain    (gain1_reg[g]),
            .product (prod[g])
        );
    end

    mdpm_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v2_reg),
        .in_final (f2_reg),
        .in_ready (merge_ready),
        .prod     (prod),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_busy |-> !(s_tvalid && s_tready))
        else $error("item taken while gains are being derived");

    a_write_rederives: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> gain_busy)
        else $error("register write did not restart gain derivation");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !measuring_reg)
        else $error("measurement still open after last item");

endmodule

`default_nettype wire
